[hdl/hit_centroid_window_cut_unit_assert.svh]
// Assertion helpers for the port checker of this block.
`ifndef HIT_CENTROID_WINDOW_CUT_UNIT_ASSERT_SVH
`define HIT_CENTROID_WINDOW_CUT_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define HCW_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("hcw port check failed");

// Next-cycle implication, disabled while reset is held.
`define HCW_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("hcw port check failed");

`endif

[hdl/hcw_pkg.sv]
package hcw_pkg;

  localparam int MAX_HITS          = 4096;
  localparam int CHANNELS_PER_SIPM = 128;
  localparam int SIPMS_PER_MAT     = 4;
  localparam int FRAC_BITS         = 8;

  localparam int POS_W  = 11;                 // max position 2047
  localparam int CNT_W  = 13;                 // 0..MAX_HITS
  localparam int SUM_W  = 23;
  localparam int QW     = SUM_W + FRAC_BITS;  // dividend / quotient width
  localparam int STEP_W = $clog2(QW);
  localparam int MEAN_W = 19;
  localparam int CFG_W  = 19;
  localparam int QDEPTH = 2;

  typedef enum logic [2:0] {
    REG_VERT_LOW   = 3'd0,
    REG_VERT_HIGH  = 3'd1,
    REG_HORIZ_LOW  = 3'd2,
    REG_HORIZ_HIGH = 3'd3,
    REG_INVERT     = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_FIN
  } back_state_t;

  // per-event accumulator snapshot, front -> back
  typedef struct packed {
    logic [SUM_W-1:0] vsum;
    logic [CNT_W-1:0] vcnt;
    logic [SUM_W-1:0] hsum;
    logic [CNT_W-1:0] hcnt;
    logic             ovf;
  } snap_t;

  typedef struct packed {
    logic [CFG_W-1:0] vert_low;
    logic [CFG_W-1:0] vert_high;
    logic [CFG_W-1:0] horiz_low;
    logic [CFG_W-1:0] horiz_high;
    logic             invert;
  } win_cfg_t;

  typedef struct packed {
    logic              count_overflow;
    logic              horiz_seen;
    logic [MEAN_W-1:0] horiz_mean;
    logic              vert_seen;
    logic [MEAN_W-1:0] vert_mean;
    logic              accept;
  } res_t;

endpackage

[hdl/hcw_queue.sv]
module hcw_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  hcw_pkg::snap_t push_data,
  input  logic          pop,
  output hcw_pkg::snap_t pop_data,
  output logic          full,
  output logic          empty
);
  import hcw_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);

  snap_t               mem_r [QDEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]      cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign full     = (cnt_r == (PTR_W+1)'(QDEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QDEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QDEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[hdl/hcw_front.sv]
module hcw_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          hit_beat,
  input  logic          hit_ok,
  input  logic          plane_vertical,
  input  logic [1:0]    mat_index,
  input  logic [1:0]    sipm_index,
  input  logic [6:0]    chan_index,
  input  logic          event_end,
  output logic          push,
  output hcw_pkg::snap_t push_data
);
  import hcw_pkg::*;

  logic [SUM_W-1:0] vsum_r, vsum_nxt, hsum_r, hsum_nxt;
  logic [CNT_W-1:0] vcnt_r, vcnt_nxt, hcnt_r, hcnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic [POS_W-1:0] pos;
  snap_t            upd;

  assign pos = POS_W'(mat_index) * POS_W'(SIPMS_PER_MAT * CHANNELS_PER_SIPM)
             + POS_W'(sipm_index) * POS_W'(CHANNELS_PER_SIPM)
             + POS_W'(chan_index);

  always_comb begin
    upd.vsum = vsum_r;
    upd.vcnt = vcnt_r;
    upd.hsum = hsum_r;
    upd.hcnt = hcnt_r;
    upd.ovf  = ovf_r;
    if (hit_ok) begin
      if (plane_vertical) begin
        if (vcnt_r >= CNT_W'(MAX_HITS)) begin
          upd.ovf = 1'b1;
        end else begin
          upd.vsum = vsum_r + SUM_W'(pos);
          upd.vcnt = vcnt_r + 1'b1;
        end
      end else begin
        if (hcnt_r >= CNT_W'(MAX_HITS)) begin
          upd.ovf = 1'b1;
        end else begin
          upd.hsum = hsum_r + SUM_W'(pos);
          upd.hcnt = hcnt_r + 1'b1;
        end
      end
    end
  end

  assign push      = hit_beat && event_end;
  assign push_data = upd;

  always_comb begin
    vsum_nxt = vsum_r;
    vcnt_nxt = vcnt_r;
    hsum_nxt = hsum_r;
    hcnt_nxt = hcnt_r;
    ovf_nxt  = ovf_r;
    if (hit_beat) begin
      if (event_end) begin
        vsum_nxt = '0;
        vcnt_nxt = '0;
        hsum_nxt = '0;
        hcnt_nxt = '0;
        ovf_nxt  = 1'b0;
      end else begin
        vsum_nxt = upd.vsum;
        vcnt_nxt = upd.vcnt;
        hsum_nxt = upd.hsum;
        hcnt_nxt = upd.hcnt;
        ovf_nxt  = upd.ovf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vsum_r <= '0;
      vcnt_r <= '0;
      hsum_r <= '0;
      hcnt_r <= '0;
      ovf_r  <= 1'b0;
    end else begin
      vsum_r <= vsum_nxt;
      vcnt_r <= vcnt_nxt;
      hsum_r <= hsum_nxt;
      hcnt_r <= hcnt_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

endmodule

[hdl/hcw_back.sv]
module hcw_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  hcw_pkg::snap_t   q_data,
  output logic             q_pop,
  input  hcw_pkg::win_cfg_t cfg,
  output logic             res_valid,
  input  logic             res_ready,
  output hcw_pkg::res_t    res
);
  import hcw_pkg::*;

  back_state_t       st_r, st_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  snap_t             snap_r, snap_nxt;
  logic [QW-1:0]     vdiv_r, vdiv_nxt, hdiv_r, hdiv_nxt;
  logic [QW-1:0]     vq_r, vq_nxt, hq_r, hq_nxt;
  logic [CNT_W-1:0]  vrem_r, vrem_nxt, hrem_r, hrem_nxt;
  logic              out_valid_r, out_valid_nxt;
  res_t              res_r, res_nxt;

  logic [CNT_W:0]    vrem_sh, hrem_sh;
  logic              vge, hge;
  logic              vseen, hseen, vpass, hpass;

  // test on exact mean via quotient and remainder: x/c vs integer bound
  function automatic logic plane_pass(input logic [QW-1:0]    q,
                                      input logic             rnz,
                                      input logic [CFG_W-1:0] lo,
                                      input logic [CFG_W-1:0] hi,
                                      input logic             inv);
    logic [QW-1:0] lo_x;
    logic [QW-1:0] hi_x;
    logic          below, above, gt_lo, lt_hi;
    lo_x  = QW'(lo);
    hi_x  = QW'(hi);
    below = q < lo_x;
    above = (q > hi_x) || ((q == hi_x) && rnz);
    gt_lo = (q > lo_x) || ((q == lo_x) && rnz);
    lt_hi = q < hi_x;
    return inv ? !(gt_lo && lt_hi) : !(below || above);
  endfunction

  // one restoring-division step per plane
  assign vrem_sh = {vrem_r, vdiv_r[QW-1]};
  assign hrem_sh = {hrem_r, hdiv_r[QW-1]};
  assign vge     = vrem_sh >= {1'b0, snap_r.vcnt};
  assign hge     = hrem_sh >= {1'b0, snap_r.hcnt};

  assign vseen = snap_r.vcnt != '0;
  assign hseen = snap_r.hcnt != '0;
  assign vpass = plane_pass(vq_r, vrem_r != '0, cfg.vert_low, cfg.vert_high, cfg.invert);
  assign hpass = plane_pass(hq_r, hrem_r != '0, cfg.horiz_low, cfg.horiz_high, cfg.invert);

  always_comb begin
    st_nxt        = st_r;
    step_nxt      = step_r;
    snap_nxt      = snap_r;
    vdiv_nxt      = vdiv_r;
    hdiv_nxt      = hdiv_r;
    vq_nxt        = vq_r;
    hq_nxt        = hq_r;
    vrem_nxt      = vrem_r;
    hrem_nxt      = hrem_r;
    res_nxt       = res_r;
    q_pop         = 1'b0;
    out_valid_nxt = out_valid_r && !res_ready;
    unique case (st_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          snap_nxt = q_data;
          vdiv_nxt = {q_data.vsum, FRAC_BITS'(0)};
          hdiv_nxt = {q_data.hsum, FRAC_BITS'(0)};
          vq_nxt   = '0;
          hq_nxt   = '0;
          vrem_nxt = '0;
          hrem_nxt = '0;
          step_nxt = '0;
          st_nxt   = BK_DIV;
        end
      end
      BK_DIV: begin
        vdiv_nxt = {vdiv_r[QW-2:0], 1'b0};
        hdiv_nxt = {hdiv_r[QW-2:0], 1'b0};
        vq_nxt   = {vq_r[QW-2:0], vge};
        hq_nxt   = {hq_r[QW-2:0], hge};
        vrem_nxt = vge ? CNT_W'(vrem_sh - {1'b0, snap_r.vcnt}) : vrem_sh[CNT_W-1:0];
        hrem_nxt = hge ? CNT_W'(hrem_sh - {1'b0, snap_r.hcnt}) : hrem_sh[CNT_W-1:0];
        if (step_r == STEP_W'(QW-1)) begin
          st_nxt = BK_FIN;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      BK_FIN: begin
        if (!out_valid_r || res_ready) begin
          res_nxt.accept         = vseen && hseen && !snap_r.ovf && vpass && hpass;
          res_nxt.vert_mean      = vseen ? vq_r[MEAN_W-1:0] : '0;
          res_nxt.vert_seen      = vseen;
          res_nxt.horiz_mean     = hseen ? hq_r[MEAN_W-1:0] : '0;
          res_nxt.horiz_seen     = hseen;
          res_nxt.count_overflow = snap_r.ovf;
          out_valid_nxt          = 1'b1;
          st_nxt                 = BK_IDLE;
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= BK_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    snap_r <= snap_nxt;
    vdiv_r <= vdiv_nxt;
    hdiv_r <= hdiv_nxt;
    vq_r   <= vq_nxt;
    hq_r   <= hq_nxt;
    vrem_r <= vrem_nxt;
    hrem_r <= hrem_nxt;
    res_r  <= res_nxt;
  end

  assign res_valid = out_valid_r;
  assign res       = res_r;

endmodule

[hdl/hit_centroid_window_cut_unit.sv]
// Flow: the beat carrying in_tlast queues an event snapshot; the back end then
//   goes through queue pop, one-bit-per-cycle division and result load to out_tvalid.
// Throughput: hits are taken one per cycle unless the event queue is full; the back
//   end divides one event at a time, a two-entry event queue absorbs short bursts.
// Reset (rst_n low, synchronous): accumulators, queue, divider FSM and output
//   valid are cleared; window registers return to their defaults.
module hit_centroid_window_cut_unit (
  input  logic        clk,
  input  logic        rst_n,
  // hit input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [1:0] mat_index, [3:2] sipm_index, [10:4] chan_index
  input  logic [1:0]  in_tuser,   // [0] hit_ok, [1] plane_vertical
  input  logic        in_tlast,   // event_end
  // per-event result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [0] accept, [19:1] vert_mean, [20] vert_seen,
                                  // [39:21] horiz_mean, [40] horiz_seen,
                                  // [41] count_overflow
  // register port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import hcw_pkg::*;

  localparam logic [CFG_W-1:0] WIN_HIGH_RST = CFG_W'(393216);

  win_cfg_t cfg_r, cfg_nxt;
  cfg_reg_t reg_sel;
  logic     cfg_wr;

  logic     hit_beat;
  logic     push, pop, q_full, q_empty;
  snap_t    push_data, pop_data;
  res_t     res;
  logic     res_valid;

  // ---------------- register file ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_sel    = cfg_reg_t'(cfg_paddr[4:2]);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (reg_sel)
        REG_VERT_LOW:   cfg_nxt.vert_low   = cfg_pwdata[CFG_W-1:0];
        REG_VERT_HIGH:  cfg_nxt.vert_high  = cfg_pwdata[CFG_W-1:0];
        REG_HORIZ_LOW:  cfg_nxt.horiz_low  = cfg_pwdata[CFG_W-1:0];
        REG_HORIZ_HIGH: cfg_nxt.horiz_high = cfg_pwdata[CFG_W-1:0];
        REG_INVERT:     cfg_nxt.invert     = cfg_pwdata[0];
        default:        cfg_nxt            = cfg_r;  // unmapped, ignored
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_VERT_LOW:   cfg_prdata = 32'(cfg_r.vert_low);
      REG_VERT_HIGH:  cfg_prdata = 32'(cfg_r.vert_high);
      REG_HORIZ_LOW:  cfg_prdata = 32'(cfg_r.horiz_low);
      REG_HORIZ_HIGH: cfg_prdata = 32'(cfg_r.horiz_high);
      REG_INVERT:     cfg_prdata = 32'(cfg_r.invert);
      default:        cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.vert_low   <= '0;
      cfg_r.vert_high  <= WIN_HIGH_RST;
      cfg_r.horiz_low  <= '0;
      cfg_r.horiz_high <= WIN_HIGH_RST;
      cfg_r.invert     <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // ---------------- front end: per-plane sums and counts ----------------
  // Stalls only when the event queue is full.
  assign in_tready = !q_full;
  assign hit_beat  = in_tvalid && in_tready;

  hcw_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .hit_beat       (hit_beat),
    .hit_ok         (in_tuser[0]),
    .plane_vertical (in_tuser[1]),
    .mat_index      (in_tdata[1:0]),
    .sipm_index     (in_tdata[3:2]),
    .chan_index     (in_tdata[10:4]),
    .event_end      (in_tlast),
    .push           (push),
    .push_data      (push_data)
  );

  // ---------------- event snapshot queue ----------------
  hcw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  // ---------------- back end: means, window cut, output register ----------------
  // Window test uses quotient and remainder, so it matches the unrounded mean.
  hcw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (pop_data),
    .q_pop     (pop),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tvalid = res_valid;
  assign out_tdata  = {6'b0, res.count_overflow, res.horiz_seen, res.horiz_mean,
                       res.vert_seen, res.vert_mean, res.accept};

endmodule

[hdl/hcw_port_checker.sv]
module hcw_port_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic        cfg_pready
);
`include "hit_centroid_window_cut_unit_assert.svh"

  logic        out_stall;
  logic        acc, vseen, hseen, ovf;
  logic [18:0] vmean, hmean;

  assign out_stall = out_tvalid && !out_tready;
  assign acc       = out_tdata[0];
  assign vmean     = out_tdata[19:1];
  assign vseen     = out_tdata[20];
  assign hmean     = out_tdata[39:21];
  assign hseen     = out_tdata[40];
  assign ovf       = out_tdata[41];

  // stalled result beat holds
  `HCW_ASSERT_NXT(a_out_hold, clk, rst_n, out_stall, out_tvalid && $stable(out_tdata))

  // a passing event has both planes and no overflow
  `HCW_ASSERT_IMP(a_accept_needs_hits, clk, rst_n, out_tvalid && acc, vseen && hseen && !ovf)

  // absent plane reports a zero mean
  `HCW_ASSERT_IMP(a_vert_mean_zero, clk, rst_n, out_tvalid && !vseen, vmean == 19'd0)
  `HCW_ASSERT_IMP(a_horiz_mean_zero, clk, rst_n, out_tvalid && !hseen, hmean == 19'd0)

  // register port never waits
  `HCW_ASSERT_IMP(a_pready_high, clk, rst_n, 1'b1, cfg_pready)

endmodule

bind hit_centroid_window_cut_unit hcw_port_checker u_port_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_pready (cfg_pready)
);

[tb/tb_hit_centroid_window_cut_unit.sv]
module tb_hit_centroid_window_cut_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import hcw_pkg::*;

  // One hit as queued for the driver. Position bits map straight onto
  // {mat, sipm, chan}, so an 11-bit position splits cleanly.
  typedef struct packed {
    logic       hit_ok;
    logic       vertical;
    logic [1:0] mat;
    logic [1:0] sipm;
    logic [6:0] chan;
    logic       last;
  } hit_beat_t;

  localparam logic [CFG_W-1:0] WIN_TOP = CFG_W'(393216);

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata    = '0;  // [1:0] mat, [3:2] sipm, [10:4] chan
  logic [1:0]  in_tuser    = '0;  // [0] hit_ok, [1] plane_vertical
  logic        in_tlast    = 1'b0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [47:0] out_tdata;         // [0] accept, [19:1] vert_mean, [20] vert_seen,
                                  // [39:21] horiz_mean, [40] horiz_seen,
                                  // [41] count_overflow
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [4:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  hit_centroid_window_cut_unit dut (.*);

  // Stimulus and checking state
  hit_beat_t   pending_hits[$];
  res_t        expected_events[$];
  hit_beat_t   drv_beat;
  res_t        want, got;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_start     = 1'b0;   // kicks off the long hold-off
  logic        hold_off       = 1'b0;   // long receiver hold-off
  int          errors         = 0;

  // Predictor state: its own accumulators and window registers
  logic [SUM_W-1:0] v_sum, h_sum;
  logic [CNT_W-1:0] v_cnt, h_cnt;
  logic             ovf_seen;
  win_cfg_t         win_model;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Long receiver hold-off, timed in cycles here
  initial begin
    @(posedge hold_start);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Hit driver: pulls the next beat when the current one is taken or none is up.
  // tvalid gets at most one NBA per edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_hits.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_beat = pending_hits.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {5'b0, drv_beat.chan, drv_beat.sipm, drv_beat.mat};
        in_tuser  <= {drv_beat.vertical, drv_beat.hit_ok};
        in_tlast  <= drv_beat.last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result side backpressure: random stalls plus the forced hold-off
  always @(posedge clk) begin
    if (!rst_n)
      out_tready <= 1'b0;
    else
      out_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  // Window test on the exact mean: sum*2^FRAC_BITS against bound*count.
  function automatic bit window_holds(longint unsigned sum, longint unsigned cnt,
                                      longint unsigned lo, longint unsigned hi);
    longint unsigned scaled;
    scaled = sum << FRAC_BITS;
    if (win_model.invert)
      return !(scaled > lo * cnt && scaled < hi * cnt);
    return !(scaled < lo * cnt || scaled > hi * cnt);
  endfunction

  task automatic track_beat(logic ok, logic vert, logic [10:0] pos, logic last);
    res_t            r;
    longint unsigned vm, hm;
    if (ok) begin
      if (vert) begin
        if (v_cnt >= MAX_HITS) ovf_seen = 1'b1;
        else begin
          v_sum = v_sum + pos;
          v_cnt = v_cnt + 1'b1;
        end
      end else begin
        if (h_cnt >= MAX_HITS) ovf_seen = 1'b1;
        else begin
          h_sum = h_sum + pos;
          h_cnt = h_cnt + 1'b1;
        end
      end
    end
    if (last) begin
      vm = (v_cnt != 0) ? (longint'(v_sum) << FRAC_BITS) / v_cnt : 0;
      hm = (h_cnt != 0) ? (longint'(h_sum) << FRAC_BITS) / h_cnt : 0;
      r                = '0;
      r.vert_seen      = v_cnt != 0;
      r.horiz_seen     = h_cnt != 0;
      r.vert_mean      = vm[MEAN_W-1:0];
      r.horiz_mean     = hm[MEAN_W-1:0];
      r.count_overflow = ovf_seen;
      r.accept         = r.vert_seen && r.horiz_seen && !ovf_seen
                      && window_holds(h_sum, h_cnt, win_model.horiz_low,
                                      win_model.horiz_high)
                      && window_holds(v_sum, v_cnt, win_model.vert_low,
                                      win_model.vert_high);
      expected_events.push_back(r);
      v_sum = '0; v_cnt = '0; h_sum = '0; h_cnt = '0; ovf_seen = 1'b0;
    end
  endtask

  // Every accepted hit beat goes through the predictor, decoded from the pins
  always @(posedge clk) begin
    if (!rst_n) begin
      v_sum = '0; v_cnt = '0; h_sum = '0; h_cnt = '0; ovf_seen = 1'b0;
    end else if (in_tvalid && in_tready) begin
      track_beat(in_tuser[0], in_tuser[1],
                 {in_tdata[1:0], in_tdata[3:2], in_tdata[10:4]}, in_tlast);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_events.size() == 0) begin
        $display("%0t: result beat with none expected, expected none, actual %h",
                 $time, out_tdata);
        errors++;
      end else begin
        want = expected_events.pop_front();
        got  = res_t'(out_tdata[41:0]);
        check_field("accept",         want.accept,         got.accept);
        check_field("vert_mean",      want.vert_mean,      got.vert_mean);
        check_field("vert_seen",      want.vert_seen,      got.vert_seen);
        check_field("horiz_mean",     want.horiz_mean,     got.horiz_mean);
        check_field("horiz_seen",     want.horiz_seen,     got.horiz_seen);
        check_field("count_overflow", want.count_overflow, got.count_overflow);
        check_field("tdata pad",      0,                   out_tdata[47:42]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Register writes: setup cycle, access cycle, then an idle wait so back to
  // back writes never double up NBAs on psel in one step.
  // ---------------------------------------------------------------------------
  task automatic write_reg(cfg_reg_t r, logic [CFG_W-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {r, 2'b00};
    cfg_pwdata  <= {13'b0, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (r)
      REG_VERT_LOW:   win_model.vert_low   = val;
      REG_VERT_HIGH:  win_model.vert_high  = val;
      REG_HORIZ_LOW:  win_model.horiz_low  = val;
      REG_HORIZ_HIGH: win_model.horiz_high = val;
      REG_INVERT:     win_model.invert     = val[0];
      default: ;
    endcase
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_windows(logic [CFG_W-1:0] vl, logic [CFG_W-1:0] vh,
                               logic [CFG_W-1:0] hl, logic [CFG_W-1:0] hh, logic inv);
    write_reg(REG_VERT_LOW, vl);
    write_reg(REG_VERT_HIGH, vh);
    write_reg(REG_HORIZ_LOW, hl);
    write_reg(REG_HORIZ_HIGH, hh);
    write_reg(REG_INVERT, {18'b0, inv});
  endtask

  // Whole channel number to a Q11.8 bound
  function automatic logic [CFG_W-1:0] q8(int unsigned c);
    return CFG_W'(c * 256);
  endfunction

  task automatic queue_hit(logic ok, logic vert, int unsigned pos, logic last);
    hit_beat_t b;
    b.hit_ok   = ok;
    b.vertical = vert;
    b.mat      = pos[10:9];
    b.sipm     = pos[8:7];
    b.chan     = pos[6:0];
    b.last     = last;
    pending_hits.push_back(b);
  endtask

  // Two-hit event, one per plane, positions in whole channels
  task automatic queue_pair(int unsigned vpos, int unsigned hpos);
    queue_hit(1'b1, 1'b1, vpos, 1'b0);
    queue_hit(1'b1, 1'b0, hpos, 1'b1);
  endtask

  // Random window in range, returns its center channel and half width
  task automatic pick_window(output logic [CFG_W-1:0] lo, output logic [CFG_W-1:0] hi,
                             output int unsigned center, output int unsigned half);
    center = $urandom_range(1535);
    half   = $urandom_range(200);
    lo = (center > half) ? CFG_W'((center - half) * 256 + $urandom_range(255))
                         : CFG_W'($urandom_range(255));
    hi = (center + half < 1536) ? CFG_W'((center + half) * 256 + $urandom_range(255))
                                : WIN_TOP;
  endtask

  function automatic int unsigned jitter(int unsigned c, int unsigned spread);
    int d;
    d = int'(c) + int'($urandom_range(2 * spread)) - int'(spread);
    if (d < 0) d = 0;
    if (d > 2047) d = 2047;
    return d;
  endfunction

  // One event: mostly hits clustered around the plane centers, now and then
  // pure noise. Counts beats that the block does not simply ignore.
  task automatic queue_event(int unsigned vc, int unsigned hc, int unsigned spread,
                             inout int unsigned counted);
    int unsigned n, pos;
    bit          noise, ok, vert, last;
    n     = $urandom_range(12, 1);
    noise = ($urandom_range(9) == 0);
    for (int unsigned i = 0; i < n; i++) begin
      ok   = noise ? 1'($urandom_range(1)) : ($urandom_range(15) != 0);
      vert = 1'($urandom_range(1));
      pos  = noise ? $urandom_range(2047) : jitter(vert ? vc : hc, spread);
      last = (i == n - 1);
      queue_hit(ok, vert, pos, last);
      if (ok || last) counted++;
    end
  endtask

  // Wait until every queued beat is taken and every result has come back,
  // then give the divider time to settle before touching registers.
  task automatic wait_idle();
    while (pending_hits.size() != 0 || in_tvalid || expected_events.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned      counted, vc, hc, vhalf, hhalf, spread, mode;
    logic [CFG_W-1:0] vl, vh, hl, hh, tmp;
    logic             inv;

    win_model = '{vert_low: '0, vert_high: WIN_TOP, horiz_low: '0,
                  horiz_high: WIN_TOP, invert: 1'b0};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset windows. Corner positions, ignored hits, empty event,
    // one-plane events, truncated mean.
    queue_hit(1'b1, 1'b1, 0, 1'b0);
    queue_hit(1'b1, 1'b0, 2047, 1'b0);           // mat 3: beyond the high bound
    queue_hit(1'b0, 1'b1, 2047, 1'b0);
    queue_hit(1'b0, 1'b0, 0, 1'b1);              // dead hit closes the event
    queue_hit(1'b0, 1'b1, 1234, 1'b1);           // no hits at all
    queue_hit(1'b1, 1'b1, 5, 1'b1);              // vertical only
    queue_hit(1'b1, 1'b0, 17, 1'b0);
    queue_hit(1'b1, 1'b0, 700, 1'b0);
    queue_hit(1'b1, 1'b0, 1535, 1'b1);           // horizontal only
    queue_hit(1'b1, 1'b1, 100, 1'b0);
    queue_hit(1'b1, 1'b1, 101, 1'b0);
    queue_hit(1'b1, 1'b1, 101, 1'b0);            // 302/3: mean truncates
    queue_hit(1'b1, 1'b0, 300, 1'b0);
    queue_hit(1'b1, 1'b0, 301, 1'b1);
    wait_idle();

    // Means on and just outside the bounds (inclusive in normal mode)
    write_windows(q8(1000), q8(1000), q8(100), q8(200), 1'b0);
    queue_pair(1000, 100);
    queue_pair(1000, 200);
    queue_pair(1000, 99);
    queue_pair(1000, 201);
    queue_pair(999, 150);
    wait_idle();
    // Inverted: a mean on a bound is not strictly inside
    write_reg(REG_INVERT, 19'd1);
    queue_pair(1000, 150);
    queue_pair(1000, 100);
    queue_pair(1000, 200);
    wait_idle();
    write_windows(q8(900), q8(1100), q8(100), q8(200), 1'b1);
    queue_pair(1000, 100);
    queue_pair(1100, 250);
    wait_idle();

    // Random phases: idle pattern rotates, windows go through reset values, random,
    // and crossed (low above high), both modes.
    for (int p = 0; p < 8; p++) begin
      mode = p % 4;
      send_idle_pct  <= (mode == 1) ? 83 : (mode == 3) ? 12 : 0;
      recv_stall_pct <= (mode == 2) ? 83 : (mode == 3) ? 12 : 0;
      pick_window(vl, vh, vc, vhalf);
      pick_window(hl, hh, hc, hhalf);
      inv = 1'($urandom_range(1));
      case (p)
        0: begin vl = '0; vh = WIN_TOP; hl = '0; hh = WIN_TOP; inv = 1'b0; end
        1: begin vl = '0; vh = WIN_TOP; hl = '0; hh = WIN_TOP; inv = 1'b1; end
        2: inv = 1'b0;
        3: inv = 1'b1;
        4, 5: begin
          tmp = vl; vl = vh; vh = tmp;
          tmp = hl; hl = hh; hh = tmp;
          inv = (p == 5);
        end
        default: ;
      endcase
      write_windows(vl, vh, hl, hh, inv);

      counted = 0;
      while (counted < 150) begin
        if (p < 2) begin
          // reset windows: spread the events over every position
          spread = $urandom_range(200);
          queue_event($urandom_range(2047), $urandom_range(2047), spread, counted);
        end else begin
          spread = $urandom_range(40);
          queue_event(jitter(vc, vhalf + 30), jitter(hc, hhalf + 30), spread, counted);
        end
      end

      // First phase: hold the result side off long enough that the event
      // queue fills and the block pushes back on hits.
      if (p == 0) begin
        hold_start <= 1'b1;
      end
      wait_idle();
    end

    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
